/* rtl/ppmd_pkg.sv */
// Package for the PPM frame decoder: opcodes, register indexes, read status
// codes, table entry encoding and configuration reset values.
// No dependencies.
package ppmd_pkg;

  typedef enum logic [1:0] {
    OP_EDGE,
    OP_OVERFLOW,
    OP_TICK,
    OP_READ
  } ppmd_op_t;

  typedef enum logic [2:0] {
    REG_CAPTURE_INPUT_COUNT,
    REG_SYNC_GAP_MIN,
    REG_PULSE_MIN,
    REG_PULSE_MAX,
    REG_STABLE_FRAMES,
    REG_MIN_CHANNEL_COUNT,
    REG_SUPERVISOR_DIVIDE
  } ppmd_reg_t;

  localparam logic [1:0] ST_VALID     = 2'd0;
  localparam logic [1:0] ST_TIMEOUT   = 2'd1;
  localparam logic [1:0] ST_BAD_INDEX = 2'd2;

  localparam int unsigned ENTRY_W = 17;
  localparam logic [16:0] ENTRY_ZERO    = 17'h00000;
  localparam logic [16:0] ENTRY_TIMEOUT = 17'h10000;

  localparam logic [5:0] SIZE_NONE = 6'h3f;

  localparam logic [3:0]  RST_CAPTURE_INPUT_COUNT = 4'd1;
  localparam logic [15:0] RST_SYNC_GAP_MIN        = 16'd3800;
  localparam logic [15:0] RST_PULSE_MIN           = 16'd750;
  localparam logic [15:0] RST_PULSE_MAX           = 16'd2250;
  localparam logic [7:0]  RST_STABLE_FRAMES       = 8'd25;
  localparam logic [4:0]  RST_MIN_CHANNEL_COUNT   = 5'd4;
  localparam logic [7:0]  RST_SUPERVISOR_DIVIDE   = 8'd25;

endpackage

/* rtl/ppmd_in_if.sv */
// Input channel of the PPM frame decoder: valid/ready handshake and item fields.
// No dependencies.
interface ppmd_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic [15:0] count;
  logic [7:0]  capture_input;
  logic [7:0]  read_channel;

  modport source (output valid, opcode, count, capture_input, read_channel, input ready);
  modport sink (input valid, opcode, count, capture_input, read_channel, output ready);
endinterface

/* rtl/ppmd_out_if.sv */
// Result channel of the PPM frame decoder: valid/ready handshake and read result.
// No dependencies.
interface ppmd_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] channel_value;
  logic [1:0]  read_status;

  modport source (output valid, channel_value, read_status, input ready);
  modport sink (input valid, channel_value, read_status, output ready);
endinterface

/* rtl/ppmd_ram.sv */
// Generic single-clock RAM with one write port and one registered read port.
// No dependencies.
module ppmd_ram #(
  parameter int unsigned WIDTH = 17,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/ppm_frame_decoder.sv */
// Top level of the PPM frame decoder: frame tracking, locking and the two
// channel tables. Depends on ppmd_pkg, ppmd_in_if, ppmd_out_if and ppmd_ram.
//
// Channel   Direction  Handshake          Word
// items     in         valid/ready        opcode, count, capture_input, read_channel
// results   out        valid/ready        channel_value, read_status
// cfg       in         cfg_write strobe   cfg_index, cfg_data
//
// One item is in work at a time. An overflow item or a quiet supervisor tick stays
// in idle, an edge passes the timestamp, delta and eval states, a read the read and
// response states plus any wait for the result slot. A frame commit copies staging
// to the committed table, a read then a write state per entry; a timeout clearance
// writes one entry per cycle. The tables reset to zero through per-entry valid bits.
// A result waiting in the output register stalls only a following read.
module ppm_frame_decoder
  import ppmd_pkg::*;
#(
  parameter int unsigned MAX_CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  ppmd_in_if.sink     items,
  ppmd_out_if.source  results
);

  localparam int unsigned IW = $clog2(MAX_CHANNELS);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_CHANNELS - 1);
  localparam logic [6:0] MAX_CH7 = 7'(MAX_CHANNELS);

  typedef enum logic [3:0] {
    S_IDLE,
    S_EDGE_TS,
    S_EDGE_DELTA,
    S_EDGE_EVAL,
    S_COPY_RD,
    S_COPY_WR,
    S_CLEAR,
    S_READ,
    S_RESP
  } state_t;

  state_t state;

  logic [3:0]  capture_input_count;
  logic [15:0] sync_gap_min;
  logic [15:0] pulse_min;
  logic [15:0] pulse_max;
  logic [7:0]  stable_frames;
  logic [4:0]  min_channel_count;
  logic [7:0]  supervisor_divide;

  logic [31:0] overflow_accum;
  logic [31:0] last_edge_time;
  logic [5:0]  pulse_position;
  logic [5:0]  locked_channels;
  logic [5:0]  previous_frame_size;
  logic [7:0]  stable_count;
  logic        tracking_flag;
  logic        fresh_flag;
  logic [7:0]  supervisor_count;

  logic [15:0] count_r;
  logic [7:0]  read_channel_r;
  logic [31:0] now_r;
  logic [31:0] delta_r;
  logic [5:0]  commit_len;
  logic        clear_committed;
  logic [IW-1:0] sweep;
  logic        stg_rd_valid;

  logic [MAX_CHANNELS-1:0] stg_valid;
  logic [MAX_CHANNELS-1:0] cmt_valid;

  logic        out_valid;
  logic [15:0] out_value;
  logic [1:0]  out_status;

  logic                 stg_we;
  logic [IW-1:0]        stg_waddr;
  logic [ENTRY_W-1:0]   stg_wdata;
  logic [ENTRY_W-1:0]   stg_rdata;
  logic                 cmt_we;
  logic [ENTRY_W-1:0]   cmt_wdata;
  logic [ENTRY_W-1:0]   cmt_rdata;

  logic        accept;
  logic        sync_gap;
  logic        good_pulse;
  logic        lock_match;
  logic [5:0]  locked_next;
  logic        do_commit;
  logic [7:0]  supervisor_count_next;
  logic [IW-1:0] read_idx;
  logic        read_in_range;
  logic        out_free;

  assign items.ready = (state == S_IDLE);
  assign accept = items.valid && items.ready;

  assign results.valid = out_valid;
  assign results.channel_value = out_value;
  assign results.read_status = out_status;

  assign sync_gap = delta_r > {16'd0, sync_gap_min};
  assign good_pulse = (delta_r > {16'd0, pulse_min}) && (delta_r < {16'd0, pulse_max})
                      && ({1'b0, pulse_position} < MAX_CH7);
  assign lock_match = (pulse_position == previous_frame_size)
                      && (pulse_position >= {1'b0, min_channel_count})
                      && ({1'b0, pulse_position} <= MAX_CH7);
  assign locked_next = (lock_match && !(stable_count < stable_frames)) ? pulse_position
                                                                       : locked_channels;
  assign do_commit = tracking_flag && (pulse_position == locked_next);
  assign supervisor_count_next = supervisor_count + 8'd1;
  assign read_idx = read_channel_r[IW-1:0];
  assign read_in_range = read_channel_r < 8'(MAX_CHANNELS);
  assign out_free = !out_valid || results.ready;

  always_comb begin
    stg_we = 1'b0;
    stg_waddr = sweep;
    stg_wdata = ENTRY_TIMEOUT;
    cmt_we = 1'b0;
    cmt_wdata = ENTRY_TIMEOUT;
    unique case (state)
      S_EDGE_EVAL: begin
        if (!sync_gap && tracking_flag && good_pulse) begin
          stg_we = 1'b1;
          stg_waddr = pulse_position[IW-1:0];
          stg_wdata = {1'b0, delta_r[15:0]};
        end
      end
      S_COPY_WR: begin
        cmt_we = 1'b1;
        if (6'(sweep) < commit_len) begin
          cmt_wdata = stg_rd_valid ? stg_rdata : ENTRY_ZERO;
        end
      end
      S_CLEAR: begin
        stg_we = 1'b1;
        cmt_we = clear_committed;
      end
      default: begin
      end
    endcase
  end

  ppmd_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_CHANNELS)) u_staging (
    .clk   (clk),
    .we    (stg_we),
    .waddr (stg_waddr),
    .wdata (stg_wdata),
    .raddr (sweep),
    .rdata (stg_rdata)
  );

  ppmd_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_CHANNELS)) u_committed (
    .clk   (clk),
    .we    (cmt_we),
    .waddr (sweep),
    .wdata (cmt_wdata),
    .raddr (read_idx),
    .rdata (cmt_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      capture_input_count <= RST_CAPTURE_INPUT_COUNT;
      sync_gap_min <= RST_SYNC_GAP_MIN;
      pulse_min <= RST_PULSE_MIN;
      pulse_max <= RST_PULSE_MAX;
      stable_frames <= RST_STABLE_FRAMES;
      min_channel_count <= RST_MIN_CHANNEL_COUNT;
      supervisor_divide <= RST_SUPERVISOR_DIVIDE;
    end else if (cfg_write) begin
      unique case (ppmd_reg_t'(cfg_index))
        REG_CAPTURE_INPUT_COUNT: capture_input_count <= cfg_data[3:0];
        REG_SYNC_GAP_MIN:        sync_gap_min <= cfg_data;
        REG_PULSE_MIN:           pulse_min <= cfg_data;
        REG_PULSE_MAX:           pulse_max <= cfg_data;
        REG_STABLE_FRAMES:       stable_frames <= cfg_data[7:0];
        REG_MIN_CHANNEL_COUNT:   min_channel_count <= cfg_data[4:0];
        REG_SUPERVISOR_DIVIDE:   supervisor_divide <= cfg_data[7:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    now_r <= {16'd0, count_r} + overflow_accum;
    stg_rd_valid <= stg_valid[sweep];
    if (accept) begin
      count_r <= items.count;
      read_channel_r <= items.read_channel;
    end
    if (state == S_EDGE_DELTA) begin
      delta_r <= now_r - last_edge_time;
    end
    if (rst) begin
      state <= S_IDLE;
      overflow_accum <= 32'd0;
      last_edge_time <= 32'd0;
      pulse_position <= 6'd0;
      locked_channels <= SIZE_NONE;
      previous_frame_size <= SIZE_NONE;
      stable_count <= 8'd0;
      tracking_flag <= 1'b0;
      fresh_flag <= 1'b0;
      supervisor_count <= 8'd0;
      commit_len <= 6'd0;
      clear_committed <= 1'b0;
      sweep <= '0;
      stg_valid <= '0;
      cmt_valid <= '0;
      out_valid <= 1'b0;
    end else begin
      if (stg_we) begin
        stg_valid[stg_waddr] <= 1'b1;
      end
      if (cmt_we) begin
        cmt_valid[sweep] <= 1'b1;
      end
      if (out_valid && results.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          sweep <= '0;
          if (accept) begin
            unique case (ppmd_op_t'(items.opcode))
              OP_EDGE: begin
                if (items.capture_input < {4'd0, capture_input_count}) begin
                  state <= S_EDGE_TS;
                end
              end
              OP_OVERFLOW: begin
                overflow_accum <= overflow_accum + {16'd0, items.count};
              end
              OP_TICK: begin
                if (supervisor_count_next < supervisor_divide) begin
                  supervisor_count <= supervisor_count_next;
                end else begin
                  supervisor_count <= 8'd0;
                  fresh_flag <= 1'b0;
                  if (!fresh_flag) begin
                    tracking_flag <= 1'b0;
                    clear_committed <= 1'b1;
                    state <= S_CLEAR;
                  end
                end
              end
              OP_READ: begin
                state <= S_READ;
              end
              default: begin
              end
            endcase
          end
        end
        S_EDGE_TS: begin
          state <= S_EDGE_DELTA;
        end
        S_EDGE_DELTA: begin
          last_edge_time <= now_r;
          state <= S_EDGE_EVAL;
        end
        S_EDGE_EVAL: begin
          state <= S_IDLE;
          if (sync_gap) begin
            if (lock_match) begin
              if (stable_count < stable_frames) begin
                stable_count <= stable_count + 8'd1;
              end
            end else begin
              stable_count <= 8'd0;
            end
            locked_channels <= locked_next;
            fresh_flag <= 1'b1;
            tracking_flag <= 1'b1;
            previous_frame_size <= pulse_position;
            pulse_position <= 6'd0;
            commit_len <= pulse_position;
            if (do_commit) begin
              state <= S_COPY_RD;
            end
          end else if (tracking_flag) begin
            if (good_pulse) begin
              pulse_position <= pulse_position + 6'd1;
            end else begin
              tracking_flag <= 1'b0;
              clear_committed <= 1'b0;
              state <= S_CLEAR;
            end
          end
        end
        S_COPY_RD: begin
          state <= S_COPY_WR;
        end
        S_COPY_WR: begin
          if (sweep == LAST_IDX) begin
            state <= S_IDLE;
          end else begin
            sweep <= sweep + 1'b1;
            state <= S_COPY_RD;
          end
        end
        S_CLEAR: begin
          if (sweep == LAST_IDX) begin
            state <= S_IDLE;
          end else begin
            sweep <= sweep + 1'b1;
          end
        end
        S_READ: begin
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            out_valid <= 1'b1;
            state <= S_IDLE;
            if (!read_in_range) begin
              out_value <= 16'd0;
              out_status <= ST_BAD_INDEX;
            end else if (!cmt_valid[read_idx]) begin
              out_value <= 16'd0;
              out_status <= ST_VALID;
            end else if (cmt_rdata[16]) begin
              out_value <= 16'd0;
              out_status <= ST_TIMEOUT;
            end else begin
              out_value <= cmt_rdata[15:0];
              out_status <= ST_VALID;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_status_zero_value: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.read_status != ST_VALID) |-> results.channel_value == 16'd0)
    else $error("non-valid read status with nonzero channel value");

  a_position_bound: assert property (@(posedge clk) disable iff (rst)
    {1'b0, pulse_position} <= MAX_CH7)
    else $error("pulse position beyond the channel table");

  a_timestamp_hold: assert property (@(posedge clk) disable iff (rst)
    (state != S_EDGE_DELTA) |=> $stable(last_edge_time))
    else $error("edge timestamp changed outside the delta step");

  a_committed_write: assert property (@(posedge clk) disable iff (rst)
    cmt_we |-> (state == S_COPY_WR || state == S_CLEAR))
    else $error("committed table written outside a sweep");

endmodule
